FILE: design/xtef_pkg.sv
// ----------------------------------------------------------------------------
// xtef_pkg
// shared codes, widths and types for the xml token event machine
// ----------------------------------------------------------------------------
`default_nettype none

package xtef_pkg;

    // handle bits kept from the lexer, never more than the 16-bit port fields
    localparam int HANDLE_BITS = 16;
    localparam int HANDLE_W    = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

    localparam int KIND_W  = 4;
    localparam int FIELD_W = 16;
    localparam int EVENT_W = 3;
    localparam int ERR_W   = 2;
    localparam int PHASE_W = 4;
    localparam int ATTR_W  = 2;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_NOT_STARTED = 4'd0;
    localparam logic [PHASE_W-1:0] PH_DECL        = 4'd1;
    localparam logic [PHASE_W-1:0] PH_CHARS       = 4'd2;
    localparam logic [PHASE_W-1:0] PH_BEGIN_STAG  = 4'd3;
    localparam logic [PHASE_W-1:0] PH_BEGIN_ETAG  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_STAG        = 4'd5;
    localparam logic [PHASE_W-1:0] PH_ETAG        = 4'd6;
    localparam logic [PHASE_W-1:0] PH_ERROR       = 4'd7;
    localparam logic [PHASE_W-1:0] PH_STOPPED     = 4'd8;

    // attribute sub-phases
    localparam logic [ATTR_W-1:0] AP_NONE = 2'd0;
    localparam logic [ATTR_W-1:0] AP_NAME = 2'd1;
    localparam logic [ATTR_W-1:0] AP_EQ   = 2'd2;

    // token kinds
    localparam logic [KIND_W-1:0] TK_XMLDECL = 4'd0;
    localparam logic [KIND_W-1:0] TK_NAME    = 4'd1;
    localparam logic [KIND_W-1:0] TK_EQ      = 4'd2;
    localparam logic [KIND_W-1:0] TK_STRING  = 4'd3;
    localparam logic [KIND_W-1:0] TK_WS      = 4'd4;
    localparam logic [KIND_W-1:0] TK_ENDPI   = 4'd5;
    localparam logic [KIND_W-1:0] TK_CHARS   = 4'd6;
    localparam logic [KIND_W-1:0] TK_STAG    = 4'd7;
    localparam logic [KIND_W-1:0] TK_ETAG    = 4'd8;
    localparam logic [KIND_W-1:0] TK_ENDSTAG = 4'd9;
    localparam logic [KIND_W-1:0] TK_ENDETAG = 4'd10;
    localparam logic [KIND_W-1:0] TK_EOF     = 4'd11;

    // event codes
    localparam logic [EVENT_W-1:0] EV_STARTDOC  = 3'd0;
    localparam logic [EVENT_W-1:0] EV_CHARS     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_STARTELEM = 3'd2;
    localparam logic [EVENT_W-1:0] EV_ENDELEM   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_ATTR      = 3'd4;
    localparam logic [EVENT_W-1:0] EV_ENDDOC    = 3'd5;
    localparam logic [EVENT_W-1:0] EV_ERROR     = 3'd6;

    // error kinds
    localparam logic [ERR_W-1:0] ER_NODECL = 2'd0;
    localparam logic [ERR_W-1:0] ER_SYNTAX = 2'd1;
    localparam logic [ERR_W-1:0] ER_NONAME = 2'd2;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic [ATTR_W-1:0]   attr;
        logic [HANDLE_W-1:0] attr_key;
        logic [HANDLE_W-1:0] elem_name;
    } xtef_state_t;

    typedef struct packed {
        logic               valid;
        logic [EVENT_W-1:0] code;
        logic [FIELD_W-1:0] name;
        logic [FIELD_W-1:0] text;
        logic [ERR_W-1:0]   err;
    } xtef_event_t;

endpackage

`default_nettype wire

FILE: design/xtef_decode.sv
// ----------------------------------------------------------------------------
// xtef_decode
// grammar step: next parse state and the event caused by one token
// ----------------------------------------------------------------------------
`default_nettype none

module xtef_decode
    import xtef_pkg::*;
(
    input  wire xtef_state_t         cur,
    input  wire logic [KIND_W-1:0]   kind,
    input  wire logic [HANDLE_W-1:0] handle,
    output xtef_state_t              nxt,
    output xtef_event_t              ev
);

    logic [FIELD_W-1:0] handle_ext;
    logic [FIELD_W-1:0] elem_ext;
    logic [FIELD_W-1:0] attr_ext;

    assign handle_ext = FIELD_W'(handle);
    assign elem_ext   = FIELD_W'(cur.elem_name);
    assign attr_ext   = FIELD_W'(cur.attr_key);

    always_comb begin
        logic fail;
        logic [ERR_W-1:0] fail_kind;

        nxt       = cur;
        ev        = '0;
        fail      = 1'b0;
        fail_kind = ER_SYNTAX;

        case (cur.phase)
            PH_NOT_STARTED: begin
                if (kind == TK_XMLDECL) begin
                    nxt.phase = PH_DECL;
                end else begin
                    fail      = 1'b1;
                    fail_kind = ER_NODECL;
                end
            end
            PH_DECL: begin
                case (kind)
                    TK_NAME: begin
                        if (cur.attr != AP_NONE) begin
                            fail = 1'b1;
                        end else begin
                            nxt.attr_key = handle;
                            nxt.attr     = AP_NAME;
                        end
                    end
                    TK_EQ: begin
                        if (cur.attr != AP_NAME) fail = 1'b1;
                        else nxt.attr = AP_EQ;
                    end
                    TK_STRING: begin
                        // declaration pairs are checked but not reported
                        if (cur.attr != AP_EQ) fail = 1'b1;
                        else nxt.attr = AP_NONE;
                    end
                    TK_WS: begin
                    end
                    TK_ENDPI: begin
                        nxt.phase = PH_CHARS;
                        ev.valid  = 1'b1;
                        ev.code   = EV_STARTDOC;
                    end
                    default: begin
                        fail = 1'b1;
                    end
                endcase
            end
            PH_CHARS: begin
                case (kind)
                    TK_CHARS: begin
                        ev.valid = 1'b1;
                        ev.code  = EV_CHARS;
                        ev.name  = handle_ext;
                    end
                    TK_STAG: nxt.phase = PH_BEGIN_STAG;
                    TK_ETAG: nxt.phase = PH_BEGIN_ETAG;
                    TK_EOF: begin
                        nxt.phase = PH_STOPPED;
                        ev.valid  = 1'b1;
                        ev.code   = EV_ENDDOC;
                    end
                    default: begin
                        fail = 1'b1;
                    end
                endcase
            end
            PH_BEGIN_STAG, PH_BEGIN_ETAG: begin
                if (kind != TK_NAME) begin
                    fail      = 1'b1;
                    fail_kind = ER_NONAME;
                end else begin
                    nxt.elem_name = handle;
                    nxt.attr      = AP_NONE;
                    ev.valid      = 1'b1;
                    ev.name       = handle_ext;
                    if (cur.phase == PH_BEGIN_STAG) begin
                        nxt.phase = PH_STAG;
                        ev.code   = EV_STARTELEM;
                    end else begin
                        nxt.phase = PH_ETAG;
                        ev.code   = EV_ENDELEM;
                    end
                end
            end
            PH_STAG: begin
                case (kind)
                    TK_ENDSTAG, TK_ENDETAG: begin
                        if (cur.attr != AP_NONE) begin
                            fail = 1'b1;
                        end else begin
                            nxt.phase = PH_CHARS;
                            // empty-element tag closes itself
                            if (kind == TK_ENDETAG) begin
                                ev.valid = 1'b1;
                                ev.code  = EV_ENDELEM;
                                ev.name  = elem_ext;
                            end
                        end
                    end
                    TK_NAME: begin
                        if (cur.attr != AP_NONE) begin
                            fail = 1'b1;
                        end else begin
                            nxt.attr_key = handle;
                            nxt.attr     = AP_NAME;
                        end
                    end
                    TK_EQ: begin
                        if (cur.attr != AP_NAME) fail = 1'b1;
                        else nxt.attr = AP_EQ;
                    end
                    TK_STRING: begin
                        if (cur.attr != AP_EQ) begin
                            fail = 1'b1;
                        end else begin
                            nxt.attr = AP_NONE;
                            ev.valid = 1'b1;
                            ev.code  = EV_ATTR;
                            ev.name  = attr_ext;
                            ev.text  = handle_ext;
                        end
                    end
                    TK_WS: begin
                    end
                    default: begin
                        fail = 1'b1;
                    end
                endcase
            end
            PH_ETAG: begin
                if (kind == TK_ENDSTAG) begin
                    if (cur.attr != AP_NONE) fail = 1'b1;
                    else nxt.phase = PH_CHARS;
                end else if (kind != TK_WS) begin
                    fail = 1'b1;
                end
            end
            default: begin
                // error, stopped and unused phases swallow tokens
            end
        endcase

        if (fail) begin
            nxt.phase = PH_ERROR;
            ev        = '0;
            ev.valid  = 1'b1;
            ev.code   = EV_ERROR;
            ev.err    = fail_kind;
        end
    end

endmodule

`default_nettype wire

FILE: design/xml_token_event_fsm.sv
// ----------------------------------------------------------------------------
// xml_token_event_fsm
// turns a stream of xml lexer tokens into sax events or a coded error
// ----------------------------------------------------------------------------
// an accepted token is held in the token register, then its event in the event register
// throughput: one token per cycle while the event register can take a result; the grammar step
// reads and writes the parse state in the same cycle that a token leaves the token register
// a waiting event still lets one more token into the token register
// reset: synchronous active-low aresetn clears both valid flags and the parse state
`default_nettype none

module xml_token_event_fsm
    import xtef_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // token_kind[3:0], value_handle[19:4], zero pad

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // event_code[2:0], name_ref[18:3],
                                        // text_ref[34:19], error_kind[36:35], zero pad
);

    logic                in_valid_reg;
    logic [KIND_W-1:0]   in_kind_reg;
    logic [HANDLE_W-1:0] in_handle_reg;

    xtef_state_t state_reg;
    xtef_state_t state_next;
    xtef_event_t ev_next;

    logic                m_valid_reg;
    logic [EVENT_W-1:0]  m_code_reg;
    logic [FIELD_W-1:0]  m_name_reg;
    logic [FIELD_W-1:0]  m_text_reg;
    logic [ERR_W-1:0]    m_err_reg;

    logic out_free;
    logic step;

    // the token in the register moves on once the event register can take a result
    assign out_free = !m_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    xtef_decode u_decode (
        .cur    (state_reg),
        .kind   (in_kind_reg),
        .handle (in_handle_reg),
        .nxt    (state_next),
        .ev     (ev_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg   <= s_tdata[3:0];
            in_handle_reg <= s_tdata[4 +: HANDLE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_NOT_STARTED, attr: AP_NONE,
                           attr_key: '0, elem_name: '0};
        end else if (step) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= step && ev_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && ev_next.valid) begin
            m_code_reg <= ev_next.code;
            m_name_reg <= ev_next.name;
            m_text_reg <= ev_next.text;
            m_err_reg  <= ev_next.err;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_err_reg, m_text_reg, m_name_reg, m_code_reg};

endmodule

`default_nettype wire

FILE: sim/xml_token_event_fsm_tb.sv
// ----------------------------------------------------------------------------
// xml_token_event_fsm_tb
// self-checking bench for the xml token event machine: a short directed
// document, then a long random walk over well-formed token sequences with
// random handles, then random tokens until an error or end of file, and a
// few more that must be ignored. a scoreboard tracks the parse state and
// checks every sax event against the oldest expected one.
// ----------------------------------------------------------------------------
module xml_token_event_fsm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xtef_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [KIND_W-1:0] TK_LEXERR = 4'd12;
    localparam logic [15:0] HANDLE_MASK = 16'((33'd1 << HANDLE_W) - 33'd1);

    typedef struct packed {
        logic [EVENT_W-1:0] code;
        logic [15:0]        name;
        logic [15:0]        text;
        logic [ERR_W-1:0]   err;
    } sax_event_t;

    class xml_event_scoreboard;
        logic [PHASE_W-1:0] phase;
        logic [ATTR_W-1:0]  attr;
        logic [15:0]        attr_key;
        logic [15:0]        elem_name;
        sax_event_t         pending_events[$];
        int                 errors;

        function new();
            phase     = PH_NOT_STARTED;
            attr      = AP_NONE;
            attr_key  = '0;
            elem_name = '0;
            errors    = 0;
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        function void push(logic [EVENT_W-1:0] code, logic [15:0] name, logic [15:0] text,
                           logic [ERR_W-1:0] err);
            sax_event_t ev;
            ev.code = code;
            ev.name = name;
            ev.text = text;
            ev.err  = err;
            pending_events.push_back(ev);
        endfunction

        function void fail(logic [ERR_W-1:0] err);
            phase = PH_ERROR;
            push(EV_ERROR, '0, '0, err);
        endfunction

        // name="value" grammar, shared by the declaration and start tags
        function bit attr_step(logic [KIND_W-1:0] kind, logic [15:0] h, bit report);
            case (kind)
                TK_NAME: begin
                    if (attr != AP_NONE) fail(ER_SYNTAX);
                    else begin
                        attr_key = h;
                        attr     = AP_NAME;
                    end
                    return 1'b1;
                end
                TK_EQ: begin
                    if (attr != AP_NAME) fail(ER_SYNTAX);
                    else attr = AP_EQ;
                    return 1'b1;
                end
                TK_STRING: begin
                    if (attr != AP_EQ) fail(ER_SYNTAX);
                    else begin
                        attr = AP_NONE;
                        if (report) push(EV_ATTR, attr_key, h, '0);
                    end
                    return 1'b1;
                end
                TK_WS: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function void note_token(logic [KIND_W-1:0] kind, logic [15:0] handle);
            logic [15:0] h;
            h = handle & HANDLE_MASK;
            case (phase)
                PH_NOT_STARTED: begin
                    if (kind == TK_XMLDECL) phase = PH_DECL;
                    else fail(ER_NODECL);
                end
                PH_DECL: begin
                    if (!attr_step(kind, h, 1'b0)) begin
                        if (kind == TK_ENDPI) begin
                            phase = PH_CHARS;
                            push(EV_STARTDOC, '0, '0, '0);
                        end else begin
                            fail(ER_SYNTAX);
                        end
                    end
                end
                PH_CHARS: begin
                    if (kind == TK_CHARS) push(EV_CHARS, h, '0, '0);
                    else if (kind == TK_STAG) phase = PH_BEGIN_STAG;
                    else if (kind == TK_ETAG) phase = PH_BEGIN_ETAG;
                    else if (kind == TK_EOF) begin
                        phase = PH_STOPPED;
                        push(EV_ENDDOC, '0, '0, '0);
                    end else begin
                        fail(ER_SYNTAX);
                    end
                end
                PH_BEGIN_STAG, PH_BEGIN_ETAG: begin
                    if (kind != TK_NAME) fail(ER_NONAME);
                    else begin
                        elem_name = h;
                        attr      = AP_NONE;
                        if (phase == PH_BEGIN_STAG) begin
                            phase = PH_STAG;
                            push(EV_STARTELEM, h, '0, '0);
                        end else begin
                            phase = PH_ETAG;
                            push(EV_ENDELEM, h, '0, '0);
                        end
                    end
                end
                PH_STAG: begin
                    if (kind == TK_ENDSTAG || kind == TK_ENDETAG) begin
                        if (attr != AP_NONE) fail(ER_SYNTAX);
                        else begin
                            phase = PH_CHARS;
                            if (kind == TK_ENDETAG) push(EV_ENDELEM, elem_name, '0, '0);
                        end
                    end else if (!attr_step(kind, h, 1'b1)) begin
                        fail(ER_SYNTAX);
                    end
                end
                PH_ETAG: begin
                    if (kind == TK_ENDSTAG) begin
                        if (attr != AP_NONE) fail(ER_SYNTAX);
                        else phase = PH_CHARS;
                    end else if (kind != TK_WS) begin
                        fail(ER_SYNTAX);
                    end
                end
                default: ; // error, stopped and unused phases swallow tokens
            endcase
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_event(logic [39:0] word);
            sax_event_t want;
            if (pending_events.size() == 0) begin
                $display("%0t: event 0x%0h expected none got one", $time, word);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_code", want.code, word[2:0]);
            compare_field("name_ref", want.name, word[18:3]);
            compare_field("text_ref", want.text, word[34:19]);
            compare_field("error_kind", want.err, word[36:35]);
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;     // token_kind[3:0], value_handle[19:4], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // event_code[2:0], name_ref[18:3], text_ref[34:19],
                                    // error_kind[36:35], zero pad

    logic rx_hold = 1'b0;
    bit   hold_go;
    bit   no_gaps;
    int   cycle_count;

    xml_event_scoreboard sb = new();

    xml_token_event_fsm u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // event side: check each transaction, then pick next cycle's ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_event(m_tdata);
        m_tready <= !rx_hold && (no_gaps || $urandom_range(0, 99) >= 32);
    end

    // long receiver stall so the token path backs up
    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    function automatic logic [15:0] random_handle();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // next token of a well-formed document, from the tracked parse state
    function automatic logic [KIND_W-1:0] next_legal_kind();
        int pick;
        pick = $urandom_range(0, 99);
        case (sb.phase)
            PH_NOT_STARTED: return TK_XMLDECL;
            PH_BEGIN_STAG, PH_BEGIN_ETAG: return TK_NAME;
            PH_CHARS: begin
                if (pick < 40) return TK_CHARS;
                return (pick < 75) ? TK_STAG : TK_ETAG;
            end
            PH_ETAG: return (pick < 30) ? TK_WS : TK_ENDSTAG;
            default: begin
                if (sb.attr == AP_NAME) return (pick < 80) ? TK_EQ : TK_WS;
                if (sb.attr == AP_EQ) return (pick < 80) ? TK_STRING : TK_WS;
                if (pick < 35) return TK_NAME;
                if (pick < 50) return TK_WS;
                if (sb.phase == PH_DECL) return TK_ENDPI;
                return (pick < 75) ? TK_ENDSTAG : TK_ENDETAG;
            end
        endcase
    endfunction

    task automatic send_token(logic [KIND_W-1:0] kind, logic [15:0] handle);
        while (!no_gaps && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, handle, kind};
        do @(posedge aclk); while (!s_tready);
        sb.note_token(kind, handle);
    endtask

    initial begin
        logic [KIND_W-1:0] kind;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // declaration with two attributes, then text and tags of every form
        send_token(TK_XMLDECL, 16'hFFFF);
        send_token(TK_WS, 16'h0000);
        send_token(TK_NAME, 16'h0001);
        send_token(TK_EQ, 16'h8000);
        send_token(TK_STRING, 16'hABCD);
        send_token(TK_NAME, 16'hFFFF);
        send_token(TK_EQ, 16'h0000);
        send_token(TK_STRING, 16'h5555);
        send_token(TK_ENDPI, 16'hAAAA);
        send_token(TK_CHARS, 16'h0000);
        send_token(TK_CHARS, 16'hFFFF);
        send_token(TK_STAG, 16'h0F0F);
        send_token(TK_NAME, 16'h1234);
        send_token(TK_WS, 16'hFFFF);
        send_token(TK_NAME, 16'hFFFF);
        send_token(TK_EQ, 16'h0001);
        send_token(TK_STRING, 16'h0000);
        send_token(TK_NAME, 16'h0000);
        send_token(TK_EQ, 16'h0000);
        send_token(TK_STRING, 16'hFFFF);
        send_token(TK_ENDSTAG, 16'h7FFF);
        send_token(TK_STAG, 16'h0000);
        send_token(TK_NAME, 16'h5A5A);
        send_token(TK_ENDETAG, 16'hFFFF);
        send_token(TK_ETAG, 16'h0000);
        send_token(TK_NAME, 16'h1234);
        send_token(TK_ENDSTAG, 16'h0000);

        // long well-formed walk with random content
        for (int i = 0; i < 1300; i++) begin
            if (i == 300) hold_go = 1'b1;
            if (i == 700) no_gaps = 1'b1;
            if (i == 900) no_gaps = 1'b0;
            send_token(next_legal_kind(), random_handle());
        end

        // random tokens until an error or end of file, then some that are ignored
        while (sb.phase != PH_ERROR && sb.phase != PH_STOPPED) begin
            kind = ($urandom_range(0, 3) == 0) ? TK_EOF : 4'($urandom_range(0, 15));
            send_token(kind, random_handle());
        end
        repeat (20) begin
            kind = ($urandom_range(0, 7) == 0) ? TK_LEXERR : 4'($urandom_range(0, 15));
            send_token(kind, random_handle());
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
